### src/mrf_pkg.sv
package mrf_pkg;

    // Longest frame that a write-multiple request may produce, CRC included.
    localparam int MAX_FRAME = 256;

    // Depth of the command queue between the front and the back part.
    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FN_READ_COILS    = 8'h01;
    localparam logic [7:0] FN_READ_INPUTS   = 8'h04;
    localparam logic [7:0] FN_WRITE_COIL    = 8'h05;
    localparam logic [7:0] FN_WRITE_REG     = 8'h06;
    localparam logic [7:0] FN_WRITE_COILS   = 8'h0F;
    localparam logic [7:0] FN_WRITE_REGS    = 8'h10;

    localparam logic [7:0] COIL_ON          = 8'hFF;
    localparam logic [7:0] COIL_OFF         = 8'h00;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_COILS = 2'd1;
    localparam logic [1:0] PH_REGS  = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [7:0]  unit_id;
        logic [7:0]  function_code;
        logic [15:0] start_address;
        logic [15:0] quantity;
        logic [15:0] data_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       status;
    } t_out_item;

    // One unit of work for the serializer: up to seven body bytes, then
    // optionally the two CRC bytes, or a single rejection result.
    typedef struct packed {
        logic [7:0][7:0] bytes;
        logic [2:0]      nbytes;
        logic            init_crc;
        logic            finish;
        logic            reject;
    } t_cmd;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### src/mrf_front.sv
module mrf_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  mrf_pkg::t_in_item i_item,
    output logic             o_cmd_valid,
    output mrf_pkg::t_cmd    o_cmd
);
    import mrf_pkg::*;

    logic [1:0]  r_phase, n_phase;
    logic [15:0] r_remain, n_remain;

    logic        multi;
    logic        supported;
    logic [16:0] coil_count;
    logic [16:0] reg_count;
    logic [16:0] byte_count;
    logic [17:0] frame_len;
    logic        rejected;
    logic [7:0]  val_hi, val_lo;
    logic        data_ends;

    assign multi      = (i_item.function_code == FN_WRITE_COILS) ||
                        (i_item.function_code == FN_WRITE_REGS);
    assign supported  = ((i_item.function_code >= FN_READ_COILS) &&
                         (i_item.function_code <= FN_WRITE_REG)) || multi;
    assign coil_count = ({1'b0, i_item.quantity} + 17'd7) >> 3;
    assign reg_count  = {i_item.quantity, 1'b0};
    assign byte_count = (i_item.function_code == FN_WRITE_COILS) ? coil_count : reg_count;
    assign frame_len  = {1'b0, byte_count} + 18'd9;
    assign rejected   = !supported ||
                        (multi && ((i_item.quantity == 16'd0) ||
                                   (byte_count > 17'd255) ||
                                   (frame_len > 18'(MAX_FRAME))));
    assign data_ends  = (r_remain <= 16'd1);

    always_comb begin
        if (i_item.function_code == FN_WRITE_COIL) begin
            val_hi = (i_item.quantity != 16'd0) ? COIL_ON : COIL_OFF;
            val_lo = COIL_OFF;
        end else begin
            val_hi = i_item.quantity[15:8];
            val_lo = i_item.quantity[7:0];
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_remain    = r_remain;
        o_cmd_valid = 1'b0;
        o_cmd       = '0;
        if (i_item.kind == KIND_HEADER) begin
            o_cmd_valid = 1'b1;
            if (rejected) begin
                o_cmd.reject = 1'b1;
                n_phase      = PH_IDLE;
                n_remain     = 16'd0;
            end else begin
                o_cmd.bytes[0] = i_item.unit_id;
                o_cmd.bytes[1] = i_item.function_code;
                o_cmd.bytes[2] = i_item.start_address[15:8];
                o_cmd.bytes[3] = i_item.start_address[7:0];
                o_cmd.bytes[4] = val_hi;
                o_cmd.bytes[5] = val_lo;
                o_cmd.bytes[6] = byte_count[7:0];
                o_cmd.nbytes   = multi ? 3'd7 : 3'd6;
                o_cmd.init_crc = 1'b1;
                o_cmd.finish   = !multi;
                if (i_item.function_code == FN_WRITE_COILS) begin
                    n_phase  = PH_COILS;
                    n_remain = byte_count[15:0];
                end else if (i_item.function_code == FN_WRITE_REGS) begin
                    n_phase  = PH_REGS;
                    n_remain = i_item.quantity;
                end else begin
                    n_phase  = PH_IDLE;
                    n_remain = 16'd0;
                end
            end
        end else if (r_phase != PH_IDLE) begin
            // A data item while idle produces nothing and leaves no trace.
            o_cmd_valid  = 1'b1;
            o_cmd.finish = data_ends;
            if (r_phase == PH_COILS) begin
                o_cmd.bytes[0] = i_item.data_value[7:0];
                o_cmd.nbytes   = 3'd1;
            end else begin
                o_cmd.bytes[0] = i_item.data_value[15:8];
                o_cmd.bytes[1] = i_item.data_value[7:0];
                o_cmd.nbytes   = 3'd2;
            end
            if (data_ends) begin
                n_phase  = PH_IDLE;
                n_remain = 16'd0;
            end else begin
                n_remain = r_remain - 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_remain <= 16'd0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_remain <= n_remain;
        end
    end

    a_idle_no_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_remain == 16'd0))
        else $error("idle phase with data still expected");

    a_busy_has_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_remain != 16'd0))
        else $error("data phase with nothing left to expect");

endmodule

### src/mrf_cmd_fifo.sv
module mrf_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  mrf_pkg::t_cmd i_wr_cmd,
    output logic          o_full,
    input  logic          i_rd,
    output mrf_pkg::t_cmd o_rd_cmd,
    output logic          o_empty
);
    import mrf_pkg::*;

    t_cmd              r_mem [CMD_DEPTH];
    logic [CMD_AW-1:0] r_wp, r_rp;
    logic [CMD_AW:0]   r_count;
    logic              do_wr, do_rd;

    assign o_full   = (r_count == (CMD_AW+1)'(CMD_DEPTH));
    assign o_empty  = (r_count == '0);
    assign do_wr    = i_wr && !o_full;
    assign do_rd    = i_rd && !o_empty;
    assign o_rd_cmd = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= r_wp + CMD_AW'(1);
            end
            if (do_rd) begin
                r_rp <= r_rp + CMD_AW'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + (CMD_AW+1)'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - (CMD_AW+1)'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (CMD_AW+1)'(CMD_DEPTH))
        else $error("command queue count out of range");

endmodule

### src/mrf_back.sv
module mrf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mrf_pkg::t_cmd     i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    output mrf_pkg::t_out_item o_result,
    output logic              o_empty,
    input  logic              i_pop
);
    import mrf_pkg::*;

    logic [2:0]  r_idx;
    logic [15:0] r_crc, n_crc;
    logic [15:0] crc_in;
    logic [3:0]  last_idx_w;
    logic [2:0]  last_idx;
    logic        emit;
    logic        done;
    t_out_item   res;

    // Two-entry result queue so the serializer keeps going while a byte waits.
    t_out_item   r_oq [2];
    logic        r_owp, r_orp;
    logic [1:0]  r_ocnt;
    logic        out_full;
    logic        out_wr, out_rd;

    assign out_full   = (r_ocnt == 2'd2);
    assign emit       = !i_cmd_empty && !out_full;
    assign last_idx_w = i_cmd.reject ? 4'd0
                                     : ({1'b0, i_cmd.nbytes} + (i_cmd.finish ? 4'd2 : 4'd0)
                                        - 4'd1);
    assign last_idx   = last_idx_w[2:0];
    assign done       = (r_idx == last_idx);
    assign o_cmd_pop  = emit && done;
    assign crc_in     = (i_cmd.init_crc && (r_idx == 3'd0)) ? CRC_INIT : r_crc;

    always_comb begin
        res   = '0;
        n_crc = r_crc;
        if (i_cmd.reject) begin
            res.last   = 1'b1;
            res.status = 1'b1;
        end else if (r_idx < i_cmd.nbytes) begin
            res.out_byte = i_cmd.bytes[r_idx];
            n_crc        = crc16_byte(crc_in, i_cmd.bytes[r_idx]);
        end else if (r_idx == i_cmd.nbytes) begin
            res.out_byte = crc_in[7:0];
        end else begin
            res.out_byte = crc_in[15:8];
            res.last     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
            r_crc <= CRC_INIT;
        end else if (emit) begin
            r_idx <= done ? 3'd0 : r_idx + 3'd1;
            r_crc <= n_crc;
        end
    end

    assign out_wr   = emit;
    assign out_rd   = i_pop && !o_empty;
    assign o_empty  = (r_ocnt == 2'd0);
    assign o_result = r_oq[r_orp];

    always_ff @(posedge i_clk) begin
        if (out_wr) begin
            r_oq[r_owp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (out_wr) begin
                r_owp <= ~r_owp;
            end
            if (out_rd) begin
                r_orp <= ~r_orp;
            end
            if (out_wr && !out_rd) begin
                r_ocnt <= r_ocnt + 2'd1;
            end else if (out_rd && !out_wr) begin
                r_ocnt <= r_ocnt - 2'd1;
            end
        end
    end

    a_out_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= 2'd2)
        else $error("result queue count out of range");

    a_reject_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_result.status) |-> o_result.last)
        else $error("rejection result without last mark");

    a_idx_in_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd_empty |-> (r_idx <= last_idx))
        else $error("serializer index beyond its command");

endmodule

### src/modbus_rtu_request_framer.sv
// The first byte of a request enters the command queue at the edge that takes its item;
// the serializer moves it into the result queue, from which it is popped.
// Throughput: one result byte per cycle while a command waits and the result queue
// has room; a short request item gives 8 bytes, a write-multiple header 7, a coil byte
// 1 (3 at frame end), a register word 2 (4 at frame end). Up to four items queue ahead.
// Reset: synchronous, active low; all queues empty, no request pending, CRC at 0xFFFF.
module modbus_rtu_request_framer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  mrf_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output mrf_pkg::t_out_item o_result
);
    import mrf_pkg::*;

    logic  accept;
    logic  cmd_valid;
    t_cmd  front_cmd;
    t_cmd  head_cmd;
    logic  cmd_empty;
    logic  cmd_pop;

    assign accept = push && !full;

    mrf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (front_cmd)
    );

    mrf_cmd_fifo u_cmd_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (accept && cmd_valid),
        .i_wr_cmd (front_cmd),
        .o_full   (full),
        .i_rd     (cmd_pop),
        .o_rd_cmd (head_cmd),
        .o_empty  (cmd_empty)
    );

    mrf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_result    (o_result),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule
